>>> rtl/s3x_pkg.sv
// Shared types and constants of the Scale3x tile upscaler.
// Used by the front, back and top-level modules; depends on nothing.
package s3x_pkg;

  // Width of the configuration write data (widest register)
  localparam int CFG_W = 11;

  // Tile size after reset, in pixels and rows
  localparam int TILE_SIZE_RST = 16;

  // Depth of the job queue between front and back
  localparam int JOB_Q_DEPTH = 2;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_TILE_WIDTH  = 1'b0,
    REG_TILE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Blocks a single source pixel releases, lowest bit first in output order.
  // upper_*: blocks of the row above; last_*: blocks of the tile's last row.
  // *_left: block of the column before; *_right: block of the row-end column.
  typedef struct packed {
    logic last_right;
    logic last_left;
    logic upper_right;
    logic upper_left;
  } blk_mask_t;

endpackage

>>> rtl/s3x_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the line store of the upscaler.
module s3x_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds its data when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/s3x_front.sv
// Front end: accepts pixels, tracks tile position, reads and updates the line store
// and builds 3x3 column windows into jobs. Uses s3x_pkg and s3x_ram.
module s3x_front #(
  parameter int MAX_TILE_WIDTH  = 1024,
  parameter int MAX_TILE_HEIGHT = 1024,
  parameter int PIXEL_BITS      = 8,
  parameter int COL_W           = 10,
  parameter int ROW_W           = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [s3x_pkg::CFG_W-1:0]   cfg_wdata_i,
  // pixel input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [PIXEL_BITS-1:0]       pixel_i,
  input  logic                        first_of_tile_i,
  // job output
  output logic                        job_valid_o,
  input  logic                        job_ready_i,
  output s3x_pkg::blk_mask_t          job_mask_o,
  output logic [COL_W-1:0]            job_col_o,
  output logic [ROW_W-1:0]            job_row_o,
  output logic [3*PIXEL_BITS-1:0]     job_up_o,
  output logic [3*PIXEL_BITS-1:0]     job_mid_o,
  output logic [3*PIXEL_BITS-1:0]     job_dn_o
);

  localparam int P     = PIXEL_BITS;
  localparam int W_RST = (s3x_pkg::TILE_SIZE_RST > MAX_TILE_WIDTH) ?
                         MAX_TILE_WIDTH : s3x_pkg::TILE_SIZE_RST;
  localparam int H_RST = (s3x_pkg::TILE_SIZE_RST > MAX_TILE_HEIGHT) ?
                         MAX_TILE_HEIGHT : s3x_pkg::TILE_SIZE_RST;
  // window rows
  localparam int WR_UP  = 0;
  localparam int WR_MID = 1;
  localparam int WR_CUR = 2;

  // Clamped sizes, stored as last column / last row index
  logic [COL_W-1:0] wlast_q, wlast_cfg;
  logic [ROW_W-1:0] hlast_q, hlast_cfg;
  logic [31:0]      cfg_val;

  // Position counters
  logic [COL_W-1:0] col_q, col_d, x_cur;
  logic [ROW_W-1:0] row_q, row_d, r_cur;
  logic             restart, accept;

  // Stage 1 (line store data available)
  logic             s1_valid_q;
  logic [COL_W-1:0] s1_x_q;
  logic [ROW_W-1:0] s1_r_q;
  logic [P-1:0]     s1_pix_q;
  logic             s1_wend_q, s1_hend_q;
  logic             fwd_q;
  logic [2*P-1:0]   fwd_data_q;
  logic             s1_adv;

  // Line store
  logic [2*P-1:0]   ram_rdata, line_rd, ram_wdata;
  logic             ram_we;
  logic [P-1:0]     up_old, mid_old;

  // Column windows: [row][tap], tap 2 is the current column
  logic [P-1:0]     win_q [3][3];
  logic [P-1:0]     win_d [3][3];
  logic [P-1:0]     new_val [3];
  logic             x_is0, x_is1;
  s3x_pkg::blk_mask_t mask;

  // Clamp a written size to 1..MAX and keep it as a last index
  always_comb begin
    cfg_val = 32'(cfg_wdata_i);
    if (cfg_val == 32'd0) begin
      wlast_cfg = '0;
      hlast_cfg = '0;
    end else begin
      if (cfg_val > 32'(MAX_TILE_WIDTH)) begin
        wlast_cfg = COL_W'(MAX_TILE_WIDTH - 1);
      end else begin
        wlast_cfg = COL_W'(cfg_val - 32'd1);
      end
      if (cfg_val > 32'(MAX_TILE_HEIGHT)) begin
        hlast_cfg = ROW_W'(MAX_TILE_HEIGHT - 1);
      end else begin
        hlast_cfg = ROW_W'(cfg_val - 32'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= COL_W'(W_RST - 1);
      hlast_q <= ROW_W'(H_RST - 1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        s3x_pkg::REG_TILE_WIDTH:  wlast_q <= wlast_cfg;
        s3x_pkg::REG_TILE_HEIGHT: hlast_q <= hlast_cfg;
        default: ;
      endcase
    end
  end

  // Position of the arriving pixel; a new tile or a stale position starts at origin
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;
  assign restart    = first_of_tile_i || (col_q > wlast_q) || (row_q > hlast_q);
  assign x_cur      = restart ? '0 : col_q;
  assign r_cur      = restart ? '0 : row_q;

  always_comb begin
    col_d = x_cur + COL_W'(1);
    row_d = r_cur;
    if (x_cur == wlast_q) begin
      col_d = '0;
      row_d = (r_cur == hlast_q) ? '0 : r_cur + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        // previous pixel writes the column being read at this edge
        fwd_q <= ram_we && (s1_x_q == x_cur);
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q     <= x_cur;
      s1_r_q     <= r_cur;
      s1_pix_q   <= pixel_i;
      s1_wend_q  <= (x_cur == wlast_q);
      s1_hend_q  <= (r_cur == hlast_q);
      fwd_data_q <= ram_wdata;
    end
  end

  // Line store: entry holds {upper, middle} of one column
  s3x_ram #(
    .WIDTH (2*P),
    .DEPTH (MAX_TILE_WIDTH),
    .AW    (COL_W)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_x_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (x_cur),
    .rdata_o (ram_rdata)
  );

  assign line_rd = fwd_q ? fwd_data_q : ram_rdata;
  assign up_old  = line_rd[2*P-1:P];
  assign mid_old = line_rd[P-1:0];

  // Row 0 fills both lines; later rows push the middle line up
  assign ram_we    = s1_adv;
  assign ram_wdata = {(s1_r_q == '0) ? s1_pix_q : mid_old, s1_pix_q};

  // Window shift with clamping at the left tile edge
  assign x_is0 = (s1_x_q == '0);
  assign x_is1 = (s1_x_q == COL_W'(1));

  always_comb begin
    new_val[WR_UP]  = up_old;
    new_val[WR_MID] = mid_old;
    new_val[WR_CUR] = s1_pix_q;
    for (int k = 0; k < 3; k++) begin
      win_d[k][2] = new_val[k];
      win_d[k][1] = x_is0 ? new_val[k] : win_q[k][2];
      win_d[k][0] = (x_is0 || x_is1) ? win_d[k][1] : win_q[k][1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      win_q <= win_d;
    end
  end

  // Blocks released by this pixel
  always_comb begin
    mask.upper_left  = (s1_r_q != '0) && !x_is0;
    mask.upper_right = (s1_r_q != '0) && s1_wend_q;
    mask.last_left   = s1_hend_q && !x_is0;
    mask.last_right  = s1_hend_q && s1_wend_q;
  end

  // Pixels that release nothing still update state but queue no job
  assign job_valid_o = s1_valid_q && (mask != '0);
  assign s1_adv      = s1_valid_q && ((mask == '0) || job_ready_i);

  assign job_mask_o = mask;
  assign job_col_o  = s1_x_q;
  assign job_row_o  = s1_r_q;
  assign job_up_o   = {win_d[WR_UP][2],  win_d[WR_UP][1],  win_d[WR_UP][0]};
  assign job_mid_o  = {win_d[WR_MID][2], win_d[WR_MID][1], win_d[WR_MID][0]};
  assign job_dn_o   = {win_d[WR_CUR][2], win_d[WR_CUR][1], win_d[WR_CUR][0]};

endmodule

>>> rtl/s3x_fifo.sv
// Small job queue with valid/ready on both sides.
// No dependencies; sits between front and back of the upscaler.
module s3x_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/s3x_back.sv
// Back end: walks the blocks of each job, applies the Scale3x rule and holds
// the result in the output register. Uses s3x_pkg.
module s3x_back #(
  parameter int PIXEL_BITS = 8,
  parameter int COL_W      = 10,
  parameter int ROW_W      = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // job input
  input  logic                    job_valid_i,
  output logic                    job_ready_o,
  input  s3x_pkg::blk_mask_t      job_mask_i,
  input  logic [COL_W-1:0]        job_col_i,
  input  logic [ROW_W-1:0]        job_row_i,
  input  logic [3*PIXEL_BITS-1:0] job_up_i,
  input  logic [3*PIXEL_BITS-1:0] job_mid_i,
  input  logic [3*PIXEL_BITS-1:0] job_dn_i,
  // result output
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [COL_W-1:0]        out_col_o,
  output logic [ROW_W-1:0]        out_row_o,
  output logic [PIXEL_BITS-1:0]   e0_o,
  output logic [PIXEL_BITS-1:0]   e1_o,
  output logic [PIXEL_BITS-1:0]   e2_o,
  output logic [PIXEL_BITS-1:0]   e3_o,
  output logic [PIXEL_BITS-1:0]   e4_o,
  output logic [PIXEL_BITS-1:0]   e5_o,
  output logic [PIXEL_BITS-1:0]   e6_o,
  output logic [PIXEL_BITS-1:0]   e7_o,
  output logic [PIXEL_BITS-1:0]   e8_o,
  output logic                    tile_done_o
);

  localparam int P     = PIXEL_BITS;
  localparam int BLK_N = $bits(s3x_pkg::blk_mask_t);

  // Scale3x rule on neighbourhood a..i around centre e
  function automatic logic [8:0][P-1:0] scale3x(
    input logic [P-1:0] a, input logic [P-1:0] b, input logic [P-1:0] c,
    input logic [P-1:0] d, input logic [P-1:0] e, input logic [P-1:0] f,
    input logic [P-1:0] g, input logic [P-1:0] h, input logic [P-1:0] i
  );
    logic [8:0][P-1:0] r;
    for (int k = 0; k < 9; k++) begin
      r[k] = e;
    end
    if (b != h && d != f) begin
      if (d == b) r[0] = d;
      if ((d == b && e != c) || (b == f && e != a)) r[1] = b;
      if (b == f) r[2] = f;
      if ((d == b && e != g) || (d == h && e != a)) r[3] = d;
      if ((b == f && e != i) || (h == f && e != c)) r[5] = f;
      if (d == h) r[6] = d;
      if ((d == h && e != i) || (h == f && e != g)) r[7] = h;
      if (h == f) r[8] = f;
    end
    return r;
  endfunction

  logic [BLK_N-1:0]   done_q, mask_v, remain, sel_v;
  s3x_pkg::blk_mask_t sel;
  logic               out_free, emit, last_blk, is_right, is_last;
  logic [P-1:0]       src [3][3];
  logic [P-1:0]       lf [3], cn [3], rt [3];
  logic [P-1:0]       na, nb, nc, nd, ne, nf, ng, nh, ni;
  logic [8:0][P-1:0]  pix_d;
  logic [COL_W-1:0]   col_d;
  logic [ROW_W-1:0]   row_d;

  logic               out_valid_q;
  logic [COL_W-1:0]   out_col_q;
  logic [ROW_W-1:0]   out_row_q;
  logic [8:0][P-1:0]  out_pix_q;
  logic               out_done_q;

  // Pick the next block still owed by the head job
  assign mask_v   = job_mask_i;
  assign remain   = mask_v & ~done_q;
  assign sel_v    = remain & (~remain + BLK_N'(1));
  assign sel      = s3x_pkg::blk_mask_t'(sel_v);
  assign last_blk = ((remain & ~sel_v) == '0);
  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = job_valid_i && out_free;
  assign job_ready_o = emit && last_blk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
    end else if (emit) begin
      done_q <= last_blk ? '0 : (done_q | sel_v);
    end
  end

  // Neighbourhood of the selected block
  assign is_right = sel.upper_right || sel.last_right;
  assign is_last  = sel.last_left || sel.last_right;

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      src[0][t] = job_up_i[t*P +: P];
      src[1][t] = job_mid_i[t*P +: P];
      src[2][t] = job_dn_i[t*P +: P];
    end
    // right-end block clamps its right neighbour to itself
    for (int k = 0; k < 3; k++) begin
      lf[k] = is_right ? src[k][1] : src[k][0];
      cn[k] = is_right ? src[k][2] : src[k][1];
      rt[k] = src[k][2];
    end
    if (is_last) begin
      // last row: current row is its own lower neighbour
      if (job_row_i != '0) begin
        na = lf[1]; nb = cn[1]; nc = rt[1];
      end else begin
        na = lf[2]; nb = cn[2]; nc = rt[2];
      end
      nd = lf[2]; ne = cn[2]; nf = rt[2];
      ng = lf[2]; nh = cn[2]; ni = rt[2];
    end else begin
      na = lf[0]; nb = cn[0]; nc = rt[0];
      nd = lf[1]; ne = cn[1]; nf = rt[1];
      ng = lf[2]; nh = cn[2]; ni = rt[2];
    end
    pix_d = scale3x(na, nb, nc, nd, ne, nf, ng, nh, ni);
    col_d = is_right ? job_col_i : job_col_i - COL_W'(1);
    row_d = is_last ? job_row_i : job_row_i - ROW_W'(1);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_col_q  <= col_d;
      out_row_q  <= row_d;
      out_pix_q  <= pix_d;
      out_done_q <= sel.last_right;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;
  assign e0_o        = out_pix_q[0];
  assign e1_o        = out_pix_q[1];
  assign e2_o        = out_pix_q[2];
  assign e3_o        = out_pix_q[3];
  assign e4_o        = out_pix_q[4];
  assign e5_o        = out_pix_q[5];
  assign e6_o        = out_pix_q[6];
  assign e7_o        = out_pix_q[7];
  assign e8_o        = out_pix_q[8];
  assign tile_done_o = out_done_q;

endmodule

>>> rtl/scale3x_tiled_upscaler_core.sv
// Scale3x tile upscaler. A block passes the stage 1 register, the job queue and the output
// register after the pixel that completes it is taken. One pixel per cycle while pixels
// release at most one block and the output is not stalled; otherwise the output side sets
// the pace at one block per cycle (two at row ends, two per pixel in the last row, four at
// its end). Reset clears position counters and sets both tile sizes to 16; the line store
// is not cleared and needs no start-up pass. Uses s3x_pkg, s3x_front, s3x_fifo, s3x_back.
module scale3x_tiled_upscaler_core #(
  parameter int MAX_TILE_WIDTH  = 1024,
  parameter int MAX_TILE_HEIGHT = 1024,
  parameter int PIXEL_BITS      = 8,
  localparam int COL_W          = (MAX_TILE_WIDTH > 1) ? $clog2(MAX_TILE_WIDTH) : 1,
  localparam int ROW_W          = (MAX_TILE_HEIGHT > 1) ? $clog2(MAX_TILE_HEIGHT) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [s3x_pkg::CFG_W-1:0] cfg_wdata_i,
  // pixel input
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [PIXEL_BITS-1:0]     pixel_i,
  input  logic                      first_of_tile_i,
  // block output
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [COL_W-1:0]          out_col_o,
  output logic [ROW_W-1:0]          out_row_o,
  output logic [PIXEL_BITS-1:0]     e0_o,
  output logic [PIXEL_BITS-1:0]     e1_o,
  output logic [PIXEL_BITS-1:0]     e2_o,
  output logic [PIXEL_BITS-1:0]     e3_o,
  output logic [PIXEL_BITS-1:0]     e4_o,
  output logic [PIXEL_BITS-1:0]     e5_o,
  output logic [PIXEL_BITS-1:0]     e6_o,
  output logic [PIXEL_BITS-1:0]     e7_o,
  output logic [PIXEL_BITS-1:0]     e8_o,
  output logic                      tile_done_o
);

  localparam int P     = PIXEL_BITS;
  localparam int BLK_N = $bits(s3x_pkg::blk_mask_t);
  localparam int JW    = BLK_N + COL_W + ROW_W + 9*P;

  // front -> queue
  logic                    fj_valid, fj_ready;
  s3x_pkg::blk_mask_t      fj_mask;
  logic [COL_W-1:0]        fj_col;
  logic [ROW_W-1:0]        fj_row;
  logic [3*P-1:0]          fj_up, fj_mid, fj_dn;
  logic [JW-1:0]           fj_data;

  // queue -> back
  logic                    bj_valid, bj_ready;
  logic [JW-1:0]           bj_data;
  s3x_pkg::blk_mask_t      bj_mask;
  logic [COL_W-1:0]        bj_col;
  logic [ROW_W-1:0]        bj_row;
  logic [3*P-1:0]          bj_up, bj_mid, bj_dn;

  s3x_front #(
    .MAX_TILE_WIDTH  (MAX_TILE_WIDTH),
    .MAX_TILE_HEIGHT (MAX_TILE_HEIGHT),
    .PIXEL_BITS      (PIXEL_BITS),
    .COL_W           (COL_W),
    .ROW_W           (ROW_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .pixel_i         (pixel_i),
    .first_of_tile_i (first_of_tile_i),
    .job_valid_o     (fj_valid),
    .job_ready_i     (fj_ready),
    .job_mask_o      (fj_mask),
    .job_col_o       (fj_col),
    .job_row_o       (fj_row),
    .job_up_o        (fj_up),
    .job_mid_o       (fj_mid),
    .job_dn_o        (fj_dn)
  );

  // Job queue decouples the pixel front from the block back
  assign fj_data = {fj_mask, fj_col, fj_row, fj_up, fj_mid, fj_dn};

  s3x_fifo #(
    .WIDTH (JW),
    .DEPTH (s3x_pkg::JOB_Q_DEPTH)
  ) u_jobq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fj_valid),
    .push_ready_o (fj_ready),
    .push_data_i  (fj_data),
    .pop_valid_o  (bj_valid),
    .pop_ready_i  (bj_ready),
    .pop_data_o   (bj_data)
  );

  assign {bj_mask, bj_col, bj_row, bj_up, bj_mid, bj_dn} = bj_data;

  s3x_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .COL_W      (COL_W),
    .ROW_W      (ROW_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bj_valid),
    .job_ready_o (bj_ready),
    .job_mask_i  (bj_mask),
    .job_col_i   (bj_col),
    .job_row_i   (bj_row),
    .job_up_i    (bj_up),
    .job_mid_i   (bj_mid),
    .job_dn_i    (bj_dn),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_col_o   (out_col_o),
    .out_row_o   (out_row_o),
    .e0_o        (e0_o),
    .e1_o        (e1_o),
    .e2_o        (e2_o),
    .e3_o        (e3_o),
    .e4_o        (e4_o),
    .e5_o        (e5_o),
    .e6_o        (e6_o),
    .e7_o        (e7_o),
    .e8_o        (e8_o),
    .tile_done_o (tile_done_o)
  );

endmodule

>>> verif/tb.sv
// Testbench for the Scale3x tile upscaler: directed table, then random tiles of
// varying size, every block checked against a typed block or the Scale3x predictor below.
// Depends on s3x_pkg and scale3x_tiled_upscaler_core.
module tb;

  localparam int MAX_TILE      = 1024;
  localparam int RANDOM_ITEMS  = 360;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 400;

  // One output block: source position, nine output pixels (e0 lowest), tile end flag
  typedef struct packed {
    logic [9:0]      col;
    logic [9:0]      row;
    logic [8:0][7:0] px;
    logic            done;
  } block_t;

  typedef enum logic {ACT_CFG, ACT_PIX} act_e;

  // Directed step: a size write or a pixel, with an optional typed-in block
  typedef struct packed {
    act_e       act;
    logic [10:0] w;
    logic [10:0] h;
    logic [7:0]  pix;
    logic        first;
    logic        typed;
    logic [9:0]  col;
    logic [9:0]  row;
    logic [7:0]  fill;
    logic        done;
  } step_t;

  logic                      clk_i;
  logic                      rst_ni          = 1'b0;
  logic                      cfg_we_i        = 1'b0;
  logic [0:0]                cfg_idx_i       = s3x_pkg::REG_TILE_WIDTH;
  logic [s3x_pkg::CFG_W-1:0] cfg_wdata_i     = '0;
  logic                      in_valid_i      = 1'b0;
  logic                      in_ready_o;
  logic [7:0]                pixel_i         = '0;
  logic                      first_of_tile_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i     = 1'b0;
  logic [9:0]                out_col_o, out_row_o;
  logic [7:0]                e0_o, e1_o, e2_o, e3_o, e4_o, e5_o, e6_o, e7_o, e8_o;
  logic                      tile_done_o;

  scale3x_tiled_upscaler_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .pixel_i, .first_of_tile_i,
    .out_valid_o, .out_ready_i, .out_col_o, .out_row_o,
    .e0_o, .e1_o, .e2_o, .e3_o, .e4_o, .e5_o, .e6_o, .e7_o, .e8_o, .tile_done_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Predictor state
  logic [7:0]  upper_store  [MAX_TILE];
  logic [7:0]  middle_store [MAX_TILE];
  logic [7:0]  prev_pix  = '0;
  logic [7:0]  prev2_pix = '0;
  int          col_pos   = 0;
  int          row_pos   = 0;
  logic [10:0] width_reg  = 11'(s3x_pkg::TILE_SIZE_RST);
  logic [10:0] height_reg = 11'(s3x_pkg::TILE_SIZE_RST);

  block_t expected_blocks [$];
  int     mismatches   = 0;
  int     idle_cycles  = 0;
  bit     quiet        = 1'b0;
  bit     force_origin = 1'b0;

  // Effective tile size: 0 acts as 1, large values saturate
  function automatic int tile_extent(input logic [10:0] v);
    if (v == 0) return 1;
    if (v > MAX_TILE) return MAX_TILE;
    return int'(v);
  endfunction

  // Left, center, right taps of a line store, clamped at the tile edges
  function automatic logic [2:0][7:0] line_taps(input bit upper, input int cx, input int w);
    int l, r;
    l = (cx > 0) ? cx - 1 : 0;
    r = (cx + 1 < w) ? cx + 1 : cx;
    if (upper) return {upper_store[r], upper_store[cx], upper_store[l]};
    return {middle_store[r], middle_store[cx], middle_store[l]};
  endfunction

  // Scale3x rule on the neighborhood A B C / D E F / G H I
  function automatic block_t scale3x_block(input int col, input int row,
                                           input logic [2:0][7:0] up,
                                           input logic [2:0][7:0] mid,
                                           input logic [2:0][7:0] dn, input logic done);
    block_t blk;
    logic [7:0] A, B, C, D, E, F, G, H, I;
    {C, B, A} = up;
    {F, E, D} = mid;
    {I, H, G} = dn;
    blk.col  = 10'(col);
    blk.row  = 10'(row);
    blk.done = done;
    blk.px   = {9{E}};
    if (B != H && D != F) begin
      if (D == B) blk.px[0] = D;
      if ((D == B && E != C) || (B == F && E != A)) blk.px[1] = B;
      if (B == F) blk.px[2] = F;
      if ((D == B && E != G) || (D == H && E != A)) blk.px[3] = D;
      if ((B == F && E != I) || (H == F && E != C)) blk.px[5] = F;
      if (D == H) blk.px[6] = D;
      if ((D == H && E != I) || (H == F && E != G)) blk.px[7] = H;
      if (H == F) blk.px[8] = F;
    end
    return blk;
  endfunction

  // Row 0 fills both stores so it serves as its own upper neighbor
  task automatic store_column(input int c, input logic [7:0] v, input int r);
    upper_store[c]  = (r == 0) ? v : middle_store[c];
    middle_store[c] = v;
  endtask

  // Blocks released by one source pixel, in output order, and state update
  task automatic predict_pixel(input logic [7:0] p, input logic first,
                               output block_t blks [4], output int n);
    int w, h, x, r, ncols, cx, pass, k;
    int cols [2];
    logic [2:0][7:0] ut, mt, ct;
    w = tile_extent(width_reg);
    h = tile_extent(height_reg);
    n = 0;
    ncols = 0;
    if (first || col_pos >= w || row_pos >= h) begin
      col_pos = 0;
      row_pos = 0;
    end
    x = col_pos;
    r = row_pos;
    if (x >= 1) begin
      cols[ncols] = x - 1;
      ncols++;
    end
    if (x == w - 1) begin
      cols[ncols] = w - 1;
      ncols++;
    end
    // pass 0: blocks of the row above; pass 1: the tile's last row
    for (pass = 0; pass < 2; pass++) begin
      if ((pass == 0 && r >= 1) || (pass == 1 && r == h - 1)) begin
        for (k = 0; k < ncols; k++) begin
          cx = cols[k];
          ut = line_taps(1'b1, cx, w);
          mt = line_taps(1'b0, cx, w);
          if (cx == x) ct = {p, p, (x >= 1) ? prev_pix : p};
          else         ct = {p, prev_pix, (x >= 2) ? prev2_pix : prev_pix};
          if (pass == 0) blks[n] = scale3x_block(cx, r - 1, ut, mt, ct, 1'b0);
          else           blks[n] = scale3x_block(cx, r, (r >= 1) ? mt : ct, ct, ct,
                                                 cx == w - 1);
          n++;
        end
      end
    end
    if (x >= 2) store_column(x - 2, prev2_pix, r);
    if (x == w - 1) begin
      if (x >= 1) store_column(x - 1, prev_pix, r);
      store_column(x, p, r);
    end
    prev2_pix = prev_pix;
    prev_pix  = p;
    col_pos   = x + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Stop feeding pixels, wait for all blocks, then let the pipeline settle
  task automatic drain_blocks();
    in_valid_i <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both size registers; a wider tile must restart at the origin so the
  // line stores never serve columns that were not written in this tile
  task automatic set_tile(input logic [10:0] w, input logic [10:0] h);
    if (tile_extent(w) > tile_extent(width_reg)) force_origin = 1'b1;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= s3x_pkg::REG_TILE_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= s3x_pkg::REG_TILE_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    width_reg  = w;
    height_reg = h;
  endtask

  // Send one pixel item; predict (or take the typed block) on acceptance
  task automatic send_pixel(input logic [7:0] p, input logic first,
                            input bit typed, input block_t typed_blk);
    int gap, n, i;
    block_t blks [4];
    logic f;
    if ($urandom_range(0, 49) == 0) quiet = ~quiet;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    f = first | force_origin;
    force_origin = 1'b0;
    in_valid_i      <= 1'b1;
    pixel_i         <= p;
    first_of_tile_i <= f;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    predict_pixel(p, f, blks, n);
    if (typed) expected_blocks.push_back(typed_blk);
    else for (i = 0; i < n; i++) expected_blocks.push_back(blks[i]);
  endtask

  // Directed steps: reset sizes, clamped sizes, tile wrap, Scale3x corner
  // patterns, single-column tall tiles
  step_t directed_steps [26] = '{
    '{ACT_PIX, 11'd0,    11'd0,    8'h00, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'hFF, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_CFG, 11'd0,    11'd0,    8'h00, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h00, 1'b0, 1'b1, 10'd0, 10'd0, 8'h00, 1'b1},
    '{ACT_PIX, 11'd0,    11'd0,    8'hFF, 1'b0, 1'b1, 10'd0, 10'd0, 8'hFF, 1'b1},
    '{ACT_PIX, 11'd0,    11'd0,    8'hA5, 1'b1, 1'b1, 10'd0, 10'd0, 8'hA5, 1'b1},
    '{ACT_CFG, 11'd2047, 11'd1,    8'h00, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h12, 1'b1, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h34, 1'b0, 1'b1, 10'd0, 10'd0, 8'h12, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h34, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h56, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_CFG, 11'd3,    11'd3,    8'h00, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h01, 1'b1, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h01, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h02, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h01, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h02, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h02, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h02, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h02, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h01, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_CFG, 11'd1,    11'd2047, 8'h00, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h77, 1'b1, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h88, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_PIX, 11'd0,    11'd0,    8'h99, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0},
    '{ACT_CFG, 11'd16,   11'd16,   8'h00, 1'b0, 1'b0, 10'd0, 10'd0, 8'h00, 1'b0}
  };

  // Pixel source: reset, directed table, random tiles, final drain
  initial begin
    int k, sent, count, area, ncolors;
    logic [10:0] w, h;
    logic [7:0] pal [3];
    logic [7:0] p;
    logic f;
    block_t typed_blk;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].act == ACT_CFG) begin
        drain_blocks();
        set_tile(directed_steps[i].w, directed_steps[i].h);
      end else begin
        typed_blk.col  = directed_steps[i].col;
        typed_blk.row  = directed_steps[i].row;
        typed_blk.px   = {9{directed_steps[i].fill}};
        typed_blk.done = directed_steps[i].done;
        send_pixel(directed_steps[i].pix, directed_steps[i].first,
                   directed_steps[i].typed, typed_blk);
      end
    end

    // Random tiles: mostly small sizes, now and then clamped extremes
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 15))
        0: begin
          w = 11'($urandom_range(1024, 2047));
          h = 11'($urandom_range(0, 1));
        end
        1: begin
          w = 11'($urandom_range(0, 3));
          h = 11'($urandom_range(1024, 2047));
        end
        2: begin
          w = 11'd0;
          h = 11'($urandom_range(0, 4));
        end
        3: begin
          w = 11'($urandom_range(1, 6));
          h = 11'd0;
        end
        default: begin
          w = 11'($urandom_range(1, 8));
          h = 11'($urandom_range(1, 6));
        end
      endcase
      drain_blocks();
      set_tile(w, h);
      area  = tile_extent(w) * tile_extent(h);
      count = area * $urandom_range(1, 3) + $urandom_range(0, 3);
      if (count > 48) count = 48;
      // few colors per tile so neighbors match and the corner rules fire
      ncolors = $urandom_range(2, 3);
      for (k = 0; k < 3; k++) pal[k] = 8'($urandom);
      for (k = 0; k < count; k++) begin
        p = ($urandom_range(0, 15) == 0) ? 8'($urandom) : pal[$urandom_range(0, ncolors - 1)];
        f = (k % area == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 59) == 0);
        if ($urandom_range(0, 79) == 0) drain_blocks();
        send_pixel(p, f, 1'b0, '0);
        sent++;
      end
    end

    drain_blocks();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Block sink with random stalls and stall-free stretches
  initial begin
    int gap;
    @(posedge clk_i);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Compare each accepted block with the oldest expected one
  always @(posedge clk_i) begin : check_blocks
    block_t seen, want;
    int i;
    bit bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.col  = out_col_o;
      seen.row  = out_row_o;
      seen.px   = {e8_o, e7_o, e6_o, e5_o, e4_o, e3_o, e2_o, e1_o, e0_o};
      seen.done = tile_done_o;
      if (expected_blocks.size() == 0) begin
        $display("%0t: block expected none got col %0d row %0d", $time,
                 seen.col, seen.row);
        mismatches++;
      end else begin
        want = expected_blocks.pop_front();
        bad = 1'b0;
        if (seen.col !== want.col)
          $display("%0t: out_col expected %0d got %0d", $time, want.col, seen.col);
        if (seen.row !== want.row)
          $display("%0t: out_row expected %0d got %0d", $time, want.row, seen.row);
        for (i = 0; i < 9; i++)
          if (seen.px[i] !== want.px[i])
            $display("%0t: e%0d expected %0h got %0h (col %0d row %0d)", $time, i,
                     want.px[i], seen.px[i], want.col, want.row);
        if (seen.done !== want.done)
          $display("%0t: tile_done expected %0b got %0b", $time, want.done, seen.done);
        if (seen !== want) bad = 1'b1;
        if (bad) mismatches++;
      end
    end
  end

  // Watchdog: too long without any item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
